// File: sv/als_pkg.sv
`timescale 1ns / 1ps

package als_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [2:0] {
		ACT_APPEND = 3'd0,
		ACT_START  = 3'd1,
		ACT_STOP   = 3'd2,
		ACT_CLEAR  = 3'd3,
		ACT_TICK   = 3'd4
	} action_t;

	localparam logic [3:0] KIND_STRAIGHT  = 4'd0;
	localparam logic [3:0] KIND_MOVE_MARK = 4'd5;
	localparam logic [3:0] KIND_DELAY     = 4'd6;
	localparam logic [3:0] KIND_CALL      = 4'd7;
	localparam logic [3:0] KIND_SEND_BYTE = 4'd10;
	localparam logic [3:0] KIND_WAIT      = 4'd11;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] operand;
		logic [7:0]  target;
		logic        target_present;
	} entry_t;

	typedef struct packed {
		entry_t      entry;
		logic [31:0] time_ms;
		logic        motion_done;
		logic        condition_true;
	} item_t;

	typedef struct packed {
		logic            running;
		logic            stopped_now;
		logic            append_dropped;
		logic            cmd_valid;
		entry_t          cmd;
		logic            cmd_first;
		logic [CNT_W-1:0] step_index;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic append;
		logic start;
		logic clear;
		logic end_reached;
		logic wrap;
		logic exec;
		logic running;
		logic stopped;
		logic dropped;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic count_full;
		logic count_zero;
		logic at_end;
		logic loop_ok;
	} dp_stat_t;

endpackage

// File: sv/als_ctrl.sv
`timescale 1ns / 1ps

module als_ctrl
	import als_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic [2:0] in_action,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		if (accept) begin
			cmd.load = 1'b1;
			case (in_action)
				ACT_APPEND: begin
					cmd.append  = !stat.count_full;
					cmd.dropped = stat.count_full;
				end
				ACT_START: begin
					if (!stat.count_zero) begin
						cmd.start = 1'b1;
						state_d   = ST_RUN;
					end
				end
				ACT_STOP: begin
					cmd.stopped = 1'b1;
					state_d     = ST_IDLE;
				end
				ACT_CLEAR: begin
					cmd.clear = 1'b1;
				end
				ACT_TICK: begin
					if (state_q == ST_RUN) begin
						if (stat.at_end) begin
							cmd.end_reached = 1'b1;
							if (stat.loop_ok) begin
								cmd.wrap = 1'b1;
								cmd.exec = 1'b1;
							end else begin
								cmd.stopped = 1'b1;
								state_d     = ST_IDLE;
							end
						end else begin
							cmd.exec = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
		cmd.running = (state_d == ST_RUN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: sv/als_datapath.sv
`timescale 1ns / 1ps

module als_datapath
	import als_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  item_t      item,
	input  ctl_cmd_t   cmd,
	output dp_stat_t   stat,
	output result_t    res
);

	entry_t            table_q [MAX_ENTRIES];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cur_q, cur_d, cur_base;
	logic [7:0]        pass_q, pass_next;
	logic [7:0]        loop_limit_q;
	logic              first_q, first_eff;
	logic [31:0]       start_q, start_eff, elapsed;
	logic [IDX_W-1:0]  rd_idx;
	entry_t            rd_entry;
	logic              done;
	result_t           res_q;

	assign pass_next = pass_q + 8'd1;

	assign stat.count_full = (count_q == CNT_W'(MAX_ENTRIES));
	assign stat.count_zero = (count_q == '0);
	assign stat.at_end     = (cur_q >= count_q);
	assign stat.loop_ok    = (loop_limit_q == '0) || (pass_next < loop_limit_q);

	// after a wrap the entry to run is the first one
	assign cur_base  = cmd.wrap ? '0 : cur_q;
	assign rd_idx    = cur_base[IDX_W-1:0];
	assign rd_entry  = table_q[rd_idx];
	assign first_eff = cmd.wrap || first_q;
	assign start_eff = first_eff ? item.time_ms : start_q;
	assign elapsed   = item.time_ms - start_eff;

	always_comb begin
		case (rd_entry.kind) inside
			[KIND_STRAIGHT:KIND_MOVE_MARK]: done = item.motion_done;
			KIND_DELAY:                     done = (elapsed >= rd_entry.operand);
			[KIND_CALL:KIND_SEND_BYTE]:     done = first_eff;
			KIND_WAIT: done = rd_entry.target_present ? item.condition_true : 1'b1;
			default:                        done = 1'b1;
		endcase
	end

	always_comb begin
		cur_d = cur_q;
		if (cmd.start || cmd.clear)
			cur_d = '0;
		else if (cmd.exec)
			cur_d = done ? cur_base + CNT_W'(1) : cur_base;
	end

	always_ff @(posedge clk) begin
		if (cmd.append)
			table_q[count_q[IDX_W-1:0]] <= item.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			cur_q        <= '0;
			pass_q       <= '0;
			first_q      <= 1'b0;
			start_q      <= '0;
			loop_limit_q <= '0;
		end else begin
			if (cfg_wr_en)
				loop_limit_q <= cfg_wr_data;
			if (cmd.append)
				count_q <= count_q + CNT_W'(1);
			else if (cmd.clear)
				count_q <= '0;
			cur_q <= cur_d;
			if (cmd.start) begin
				pass_q  <= '0;
				first_q <= 1'b1;
			end else begin
				if (cmd.end_reached && loop_limit_q != '0)
					pass_q <= pass_next;
				if (cmd.exec) begin
					start_q <= start_eff;
					first_q <= done;
				end
			end
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q.running        <= cmd.running;
			res_q.stopped_now    <= cmd.stopped;
			res_q.append_dropped <= cmd.dropped;
			res_q.cmd_valid      <= cmd.exec;
			res_q.cmd            <= cmd.exec ? rd_entry : '0;
			res_q.cmd_first      <= cmd.exec && first_eff;
			res_q.step_index     <= cur_d;
		end
	end

	assign res = res_q;

endmodule

// File: sv/action_list_sequencer.sv
`timescale 1ns / 1ps

// Action list sequencer. Items arrive as beats on the s_ side (action in s_tuser)
// and each accepted beat gives exactly one result beat on the m_ side. A beat is
// taken every cycle while the result register is empty or being drained: the whole
// item (table read at the current step, delay compare, state update) settles
// combinationally and the result is registered, so it appears in the next cycle;
// the rate is one item per cycle. The program table is 32 entries; entries never
// written read as undefined. The user must set loop_limit through cfg_wr_en and
// cfg_wr_data while no beat is in flight, unchecked; zero repeats the list forever.
module action_list_sequencer
	import als_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,  // loop_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	// entry_kind, entry_operand, entry_target, entry_target_present, time_ms,
	// motion_done, condition_true, zero pad
	input  logic [79:0] s_tdata,
	input  logic [2:0]  s_tuser,      // action
	output logic        m_tvalid,
	input  logic        m_tready,
	// running, stopped_now, append_dropped, cmd_valid, cmd_kind, cmd_operand,
	// cmd_target, cmd_target_present, cmd_first, step_index
	output logic [55:0] m_tdata
);

	item_t    item;
	ctl_cmd_t cmd;
	dp_stat_t stat;
	result_t  res;

	assign item.entry.kind           = s_tdata[3:0];
	assign item.entry.operand        = s_tdata[35:4];
	assign item.entry.target         = s_tdata[43:36];
	assign item.entry.target_present = s_tdata[44];
	assign item.time_ms              = s_tdata[76:45];
	assign item.motion_done          = s_tdata[77];
	assign item.condition_true       = s_tdata[78];

	als_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	als_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item        (item),
		.cmd         (cmd),
		.stat        (stat),
		.res         (res)
	);

	assign m_tdata = {res.step_index, res.cmd_first, res.cmd.target_present,
		res.cmd.target, res.cmd.operand, res.cmd.kind, res.cmd_valid,
		res.append_dropped, res.stopped_now, res.running};

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench
	import als_pkg::*;
();

	localparam int HANG_LIMIT = 5000;
	localparam int LONG_HOLD  = 400;
	localparam logic [2:0] ACT_FIRST_SPARE = 3'd5;

	// s_tdata layout, lowest field last
	typedef struct packed {
		logic        pad;
		logic        condition_true;
		logic        motion_done;
		logic [31:0] time_ms;
		logic        target_present;
		logic [7:0]  target;
		logic [31:0] operand;
		logic [3:0]  kind;
	} beat_in_t;

	// m_tdata layout, lowest field last
	typedef struct packed {
		logic [5:0]  step_index;
		logic        cmd_first;
		logic        cmd_target_present;
		logic [7:0]  cmd_target;
		logic [31:0] cmd_operand;
		logic [3:0]  cmd_kind;
		logic        cmd_valid;
		logic        append_dropped;
		logic        stopped_now;
		logic        running;
	} beat_out_t;

	typedef struct {
		logic [2:0] act;
		beat_in_t   data;
	} seq_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;

	seq_item_t pending_q[$];
	beat_out_t expected_q[$];
	seq_item_t offered;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int failures = 0;
	int pushed_total = 0;
	int results_seen = 0;
	int stim_items = 0;
	logic [31:0] now_ms = '0;

	// predictor state
	entry_t      prog [MAX_ENTRIES];
	int          prog_len = 0;
	int          step_ptr = 0;
	logic [7:0]  pass_cnt = '0;
	bit          seq_running = 1'b0;
	bit          on_first = 1'b0;
	logic [31:0] entry_t0_ms = '0;
	logic [7:0]  loop_cfg = '0;

	action_list_sequencer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit entry_finished(int idx, beat_in_t d);
		entry_t e;
		e = prog[idx];
		if (e.kind <= KIND_MOVE_MARK)
			return d.motion_done;
		if (e.kind == KIND_DELAY)
			return (d.time_ms - entry_t0_ms) >= e.operand;
		if (e.kind >= KIND_CALL && e.kind <= KIND_SEND_BYTE)
			return on_first;
		if (e.kind == KIND_WAIT)
			return e.target_present ? d.condition_true : 1'b1;
		return 1'b1;
	endfunction

	function automatic beat_out_t sequence_step(seq_item_t it);
		beat_out_t  r;
		logic [7:0] nxt;
		int         idx;
		bit         go;
		r = '0;
		go = 1'b1;
		case (it.act)
			ACT_APPEND: begin
				if (prog_len < MAX_ENTRIES) begin
					prog[prog_len].kind = it.data.kind;
					prog[prog_len].operand = it.data.operand;
					prog[prog_len].target = it.data.target;
					prog[prog_len].target_present = it.data.target_present;
					prog_len++;
				end else
					r.append_dropped = 1'b1;
			end
			ACT_START: begin
				if (prog_len > 0) begin
					seq_running = 1'b1;
					step_ptr = 0;
					pass_cnt = '0;
					on_first = 1'b1;
				end
			end
			ACT_STOP: begin
				seq_running = 1'b0;
				r.stopped_now = 1'b1;
			end
			ACT_CLEAR: begin
				prog_len = 0;
				step_ptr = 0;
			end
			ACT_TICK: begin
				if (seq_running) begin
					if (step_ptr >= prog_len) begin
						nxt = pass_cnt + 8'd1;
						if (loop_cfg == 0) begin
							step_ptr = 0;
							on_first = 1'b1;
						end else if (nxt < loop_cfg) begin
							pass_cnt = nxt;
							step_ptr = 0;
							on_first = 1'b1;
						end else begin
							// last pass done: behaves as a stop
							pass_cnt = nxt;
							seq_running = 1'b0;
							r.stopped_now = 1'b1;
							go = 1'b0;
						end
					end
					if (go) begin
						idx = (step_ptr < MAX_ENTRIES) ? step_ptr : 0;
						if (on_first)
							entry_t0_ms = it.data.time_ms;
						r.cmd_valid = 1'b1;
						r.cmd_first = on_first;
						r.cmd_kind = prog[idx].kind;
						r.cmd_operand = prog[idx].operand;
						r.cmd_target = prog[idx].target;
						r.cmd_target_present = prog[idx].target_present;
						if (entry_finished(idx, it.data)) begin
							step_ptr++;
							on_first = 1'b1;
						end else
							on_first = 1'b0;
					end
				end
			end
			default: ;
		endcase
		r.running = seq_running;
		r.step_index = step_ptr[5:0];
		return r;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_q.push_back(sequence_step(offered));
			if (!s_tvalid || s_tready) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = pending_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= offered.data;
					s_tuser <= offered.act;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endtask

	task automatic check_result(beat_out_t got);
		beat_out_t want;
		if (expected_q.size() == 0) begin
			$error("result beat with nothing expected: %h", got);
			failures++;
			return;
		end
		want = expected_q.pop_front();
		check_field("running", want.running, got.running);
		check_field("stopped_now", want.stopped_now, got.stopped_now);
		check_field("append_dropped", want.append_dropped, got.append_dropped);
		check_field("cmd_valid", want.cmd_valid, got.cmd_valid);
		check_field("cmd_kind", want.cmd_kind, got.cmd_kind);
		check_field("cmd_operand", want.cmd_operand, got.cmd_operand);
		check_field("cmd_target", want.cmd_target, got.cmd_target);
		check_field("cmd_target_present", want.cmd_target_present, got.cmd_target_present);
		check_field("cmd_first", want.cmd_first, got.cmd_first);
		check_field("step_index", want.step_index, got.step_index);
	endtask

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result(beat_out_t'(m_tdata));
				results_seen++;
			end
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= HANG_LIMIT) begin
			$display("action_list_sequencer: mismatch");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	function automatic beat_in_t random_data();
		beat_in_t d;
		d.kind = 4'($urandom_range(15));
		d.operand = $urandom();
		d.target = 8'($urandom_range(255));
		d.target_present = 1'($urandom_range(1));
		d.time_ms = $urandom();
		d.motion_done = 1'($urandom_range(1));
		d.condition_true = 1'($urandom_range(1));
		d.pad = 1'b0;
		return d;
	endfunction

	function automatic entry_t mk_entry(logic [3:0] kind, logic [31:0] op, logic [7:0] tgt,
			logic pres);
		entry_t e;
		e.kind = kind;
		e.operand = op;
		e.target = tgt;
		e.target_present = pres;
		return e;
	endfunction

	function automatic entry_t random_entry();
		entry_t e;
		e = mk_entry(4'($urandom_range(15)), $urandom(), 8'($urandom_range(255)),
			1'($urandom_range(1)));
		if ($urandom_range(3) == 0)
			e.kind = KIND_DELAY;
		// mostly short delays so the list keeps moving
		if (e.kind == KIND_DELAY && $urandom_range(7) != 0)
			e.operand = $urandom_range(30);
		return e;
	endfunction

	task automatic push_raw(logic [2:0] act, beat_in_t d);
		seq_item_t it;
		it.act = act;
		it.data = d;
		pending_q.push_back(it);
		pushed_total++;
		if (act < ACT_FIRST_SPARE)
			stim_items++;
	endtask

	task automatic push_ctl(logic [2:0] act);
		push_raw(act, random_data());
	endtask

	task automatic push_append(entry_t e);
		beat_in_t d;
		d = random_data();
		d.kind = e.kind;
		d.operand = e.operand;
		d.target = e.target;
		d.target_present = e.target_present;
		push_raw(ACT_APPEND, d);
	endtask

	task automatic push_tick(logic [31:0] t, bit motion, bit cond);
		beat_in_t d;
		d = random_data();
		d.time_ms = t;
		d.motion_done = motion;
		d.condition_true = cond;
		push_raw(ACT_TICK, d);
	endtask

	task automatic push_random_tick();
		if ($urandom_range(9) == 0)
			now_ms += $urandom();
		else
			now_ms += $urandom_range(8);
		push_tick(now_ms, $urandom_range(99) < 40, $urandom_range(99) < 40);
	endtask

	// well-formed program with occasional interference while it runs
	task automatic run_program(int n_entries, int n_ticks);
		int r;
		push_ctl(ACT_CLEAR);
		repeat (n_entries) push_append(random_entry());
		push_ctl(ACT_START);
		repeat (n_ticks) begin
			r = $urandom_range(99);
			if (r < 2)
				push_ctl(ACT_STOP);
			else if (r < 4)
				push_append(random_entry());
			else if (r < 5)
				push_ctl(ACT_CLEAR);
			else if (r < 6)
				push_ctl(ACT_START);
			else
				push_random_tick();
		end
	endtask

	task automatic wait_drained();
		while (results_seen != pushed_total)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_loop_limit(logic [7:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		loop_cfg = v;
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, logic [7:0] limit, int n_items,
			bit long_hold);
		int goal;
		int r;
		wait_drained();
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		write_loop_limit(limit);
		if (long_hold)
			hold_req = 1'b1;
		goal = stim_items + n_items;
		while (stim_items < goal) begin
			r = $urandom_range(99);
			if (r < 8) begin
				repeat (15) push_raw(3'($urandom_range(7)), random_data());
			end else if (r < 14) begin
				// overfill the table
				push_ctl(ACT_CLEAR);
				repeat (MAX_ENTRIES + $urandom_range(1, 3)) push_append(random_entry());
				push_ctl(ACT_START);
				repeat (40) push_random_tick();
			end else if (r < 85)
				run_program($urandom_range(1, 6), $urandom_range(20, 60));
			else
				run_program($urandom_range(7, 20), $urandom_range(40, 90));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		write_loop_limit(8'd1);
		push_tick(32'd0, 1'b1, 1'b1);            // tick while idle
		push_ctl(ACT_START);                      // start with empty table
		push_ctl(ACT_STOP);                       // stop while idle
		for (int a = ACT_FIRST_SPARE; a < 8; a++)
			push_raw(3'(a), random_data());
		push_append(mk_entry(KIND_STRAIGHT, '0, '0, 1'b0));
		push_append(mk_entry(4'hf, '1, '1, 1'b1));
		push_append(mk_entry(KIND_DELAY, 32'd3, 8'd1, 1'b0));
		push_append(mk_entry(KIND_WAIT, 32'd0, 8'd0, 1'b0));
		push_append(mk_entry(KIND_WAIT, 32'd9, 8'd5, 1'b1));
		push_append(mk_entry(KIND_CALL, 32'd77, 8'd2, 1'b1));
		push_append(mk_entry(KIND_SEND_BYTE, 32'h5a, 8'd3, 1'b0));
		push_ctl(ACT_START);
		push_tick(32'd10, 1'b0, 1'b1);           // motion not done yet
		push_tick(32'd11, 1'b1, 1'b0);
		push_tick(32'd12, 1'b0, 1'b0);           // unassigned kind completes at once
		push_tick(32'hffff_fffe, 1'b0, 1'b0);    // delay across the time wrap
		push_tick(32'hffff_ffff, 1'b0, 1'b0);
		push_tick(32'd1, 1'b0, 1'b0);
		push_tick(32'd2, 1'b0, 1'b0);            // wait without target
		push_tick(32'd3, 1'b1, 1'b0);
		push_tick(32'd4, 1'b0, 1'b1);
		push_tick(32'd5, 1'b0, 1'b0);
		push_tick(32'd6, 1'b0, 1'b0);
		push_tick(32'd7, 1'b0, 1'b0);            // end of list, single pass
		push_ctl(ACT_START);
		push_ctl(ACT_CLEAR);                      // clear while running
		push_tick(32'd8, 1'b1, 1'b0);
		push_append(mk_entry(KIND_CALL, 32'd1, 8'd0, 1'b0));
		push_tick(32'd9, 1'b1, 1'b0);
		push_ctl(ACT_STOP);

		run_phase(0, 0, 8'd0, 290, 1'b0);
		run_phase(60, 0, 8'd1, 290, 1'b0);
		run_phase(0, 60, 8'd255, 290, 1'b0);
		now_ms = 32'hffff_ff00;
		run_phase(21, 21, 8'd2, 290, 1'b0);
		run_phase(0, 0, 8'($urandom_range(3, 254)), 290, 1'b1);
		run_phase(0, 0, 8'd3, 290, 1'b0);

		wait_drained();
		repeat (5) @(posedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d expected results never arrived", expected_q.size());
			failures++;
		end
		if (failures == 0)
			$display("action_list_sequencer: match");
		else
			$display("action_list_sequencer: mismatch");
		$finish;
	end

endmodule
